// File: rtl/core/contour_gap_closing_3x3_assert.svh
// assertion macros shared by the contour gap closing rtl
// expects signals named clk and rst in the scope where a macro is used
`ifndef CONTOUR_GAP_CLOSING_3X3_ASSERT_SVH
`define CONTOUR_GAP_CLOSING_3X3_ASSERT_SVH

// same-cycle implication
`define CGC_ASSERT_IMPL(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("cgc assertion failed");

// next-cycle implication
`define CGC_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("cgc assertion failed");

`endif

// File: rtl/core/cgc_pkg.sv
// shared types, constants and the gap test for the contour gap closing block
// no dependencies
`default_nettype none

package cgc_pkg;

  localparam int MAX_WIDTH_DEFAULT = 2048;
  localparam int QUEUE_DEPTH       = 4;
  localparam int PIX_W             = 8;
  localparam int CFG_WIDTH_W       = 12;
  localparam int CFG_HEIGHT_W      = 13;
  localparam int ROW_W             = 13;
  localparam int MIN_SIZE          = 3;
  localparam int HEIGHT_LIMIT      = 4096;
  localparam int WIDTH_RESET       = 640;
  localparam int HEIGHT_RESET      = 480;
  localparam int APB_ADDR_W        = 3;
  localparam int APB_DATA_W        = 32;

  localparam logic [PIX_W-1:0] FILL_VALUE = 8'd255;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_DRAIN = 1'b1
  } cmd_t;

  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_idx_t;

  // per-item decisions made by the front end
  typedef struct packed {
    logic emit;
    logic interior;
    logic last;
  } item_flags_t;

  // back end status seen by the top level
  typedef struct packed {
    logic busy;
    logic advance;
  } back_status_t;

  // four directions, each tested against the three cells on the opposite side of the center pixel
  function automatic logic gap_found(
    input logic [PIX_W-1:0] nw, input logic [PIX_W-1:0] n,  input logic [PIX_W-1:0] ne,
    input logic [PIX_W-1:0] w,  input logic [PIX_W-1:0] e,
    input logic [PIX_W-1:0] sw, input logic [PIX_W-1:0] s,  input logic [PIX_W-1:0] se
  );
    logic bnw, bn, bne, bw, be, bsw, bs, bse;
    bnw = (nw != '0);
    bn  = (n  != '0);
    bne = (ne != '0);
    bw  = (w  != '0);
    be  = (e  != '0);
    bsw = (sw != '0);
    bs  = (s  != '0);
    bse = (se != '0);
    return (be  && (bnw || bw  || bsw)) ||
           (bne && (bw  || bsw || bs )) ||
           (bn  && (bsw || bs  || bse)) ||
           (bnw && (bs  || bse || be ));
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/contour_gap_closing_3x3.sv
// top level of the 3x3 contour gap closing filter: apb registers and wiring
// depends on cgc_pkg, cgc_front, cgc_queue, cgc_back and the assertion macros
//
// Streams an 8-bit edge image in raster order at one item per clock while
// neither side stalls and returns the closed image: an interior pixel becomes
// 255 when a nonzero neighbour faces a nonzero cell on the opposite side,
// borders pass as they are. Throughput is one transfer per cycle on each side
// while neither side stalls; the line buffers are a single MAX_WIDTH x 16
// memory read and written once per item, which sets that pace. The result for
// pixel (r,c) leaves once the pixel at (r+1,c+1) has passed queue entry, then
// memory read and window stage into the output register. After a frame's last pixel, send
// image_width+1 drain ticks (cmd=1) to flush the tail; the final pixel comes
// with last_of_frame. Drain ticks sent early are swallowed, and a pixel sent
// mid-drain starts a new frame. Register writes restart the frame and must
// happen while the block is idle. Width is clamped to 3..MAX_WIDTH and height
// to 3..4096. The line buffer needs no clearing after reset.
`default_nettype none

`include "contour_gap_closing_3x3_assert.svh"

module contour_gap_closing_3x3 import cgc_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // apb configuration port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0]      prdata,
  output logic                       pready,
  // input items
  input  wire logic                  item_valid,
  output logic                       item_stall,
  input  wire logic                  cmd,
  input  wire logic [PIX_W-1:0]      pixel_in,
  // result items
  output logic                       result_valid,
  input  wire logic                  result_stall,
  output logic [PIX_W-1:0]           pixel_out,
  output logic                       last_of_frame
);

  localparam int AW      = $clog2(MAX_WIDTH);
  localparam int FLAG_W  = $bits(item_flags_t);
  localparam int QDATA_W = FLAG_W + AW + PIX_W;

  logic [CFG_WIDTH_W-1:0]  image_width;
  logic [CFG_HEIGHT_W-1:0] image_height;
  logic                    cfg_write;
  reg_idx_t                reg_sel;

  // front end to queue
  logic                    q_push;
  logic [PIX_W-1:0]        push_pixel;
  logic [AW-1:0]           push_col;
  item_flags_t             push_flags;
  logic                    q_full;

  // queue to back end
  logic [QDATA_W-1:0]      q_data;
  logic                    q_valid;
  logic                    q_pop;
  back_status_t            back_status;

  // ---------------------------------------------------------------------------
  // configuration registers, always ready, word decode on paddr bit 2
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign reg_sel   = reg_idx_t'(paddr[2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= CFG_WIDTH_W'(WIDTH_RESET);
      image_height <= CFG_HEIGHT_W'(HEIGHT_RESET);
    end else if (cfg_write) begin
      case (reg_sel)
        REG_IMAGE_WIDTH:  image_width  <= pwdata[CFG_WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[CFG_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(image_width);
      REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(image_height);
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // front end: raster position, drain ticks, frame restart, classification
  // ---------------------------------------------------------------------------
  cgc_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .restart      (cfg_write),
    .image_width  (image_width),
    .image_height (image_height),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .cmd          (cmd),
    .pixel_in     (pixel_in),
    .push         (q_push),
    .push_pixel   (push_pixel),
    .push_col     (push_col),
    .push_flags   (push_flags),
    .q_full       (q_full)
  );

  // ---------------------------------------------------------------------------
  // decoupling queue, each entry is {flags, column, pixel}
  // ---------------------------------------------------------------------------
  cgc_queue #(
    .DATA_W (QDATA_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data ({push_flags, push_col, push_pixel}),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .not_empty (q_valid)
  );

  // ---------------------------------------------------------------------------
  // back end: line buffers, window shift, gap fill, output transfer
  // ---------------------------------------------------------------------------
  cgc_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_pixel       (q_data[PIX_W-1:0]),
    .q_col         (q_data[PIX_W +: AW]),
    .q_flags       (item_flags_t'(q_data[QDATA_W-1 -: FLAG_W])),
    .q_pop         (q_pop),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .pixel_out     (pixel_out),
    .last_of_frame (last_of_frame),
    .status        (back_status)
  );

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // front end never pushes into a full queue
  `CGC_ASSERT_IMPL(a_no_overflow, q_push, !q_full)
  // back end only pops real entries
  `CGC_ASSERT_IMPL(a_no_underflow, q_pop, q_valid)
  // a pushed item is visible to the back end on the next cycle
  `CGC_ASSERT_NEXT(a_push_visible, q_push, q_valid)
  // a new result only appears after the back end moved an item
  `CGC_ASSERT_IMPL(a_result_from_advance, $rose(result_valid), $past(back_status.advance))
  // a pop only lands in a free or moving stage
  `CGC_ASSERT_IMPL(a_pop_into_free, q_pop, !back_status.busy || back_status.advance)

endmodule

`default_nettype wire

// File: rtl/core/cgc_queue.sv
// small fifo between the front end and the back end
// depends on cgc_pkg for the default depth
`default_nettype none

module cgc_queue import cgc_pkg::*; #(
  parameter int DATA_W = 16,
  parameter int DEPTH  = QUEUE_DEPTH,
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW    = $clog2(DEPTH + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire logic [DATA_W-1:0] push_data,
  output logic                   full,
  input  wire logic              pop,
  output logic [DATA_W-1:0]      pop_data,
  output logic                   not_empty
);

  logic [DATA_W-1:0] entries [DEPTH];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic [CW-1:0]     count;
  logic              do_push;
  logic              do_pop;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/cgc_front.sv
// front end: raster counters, drain handling and per-item classification
// depends on cgc_pkg
`default_nettype none

module cgc_front import cgc_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT,
  localparam int AW       = $clog2(MAX_WIDTH),
  localparam int WD_W     = $clog2(MAX_WIDTH + 1)
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    restart,
  input  wire logic [CFG_WIDTH_W-1:0]  image_width,
  input  wire logic [CFG_HEIGHT_W-1:0] image_height,
  input  wire logic                    item_valid,
  output logic                         item_stall,
  input  wire logic                    cmd,
  input  wire logic [PIX_W-1:0]        pixel_in,
  output logic                         push,
  output logic [PIX_W-1:0]             push_pixel,
  output logic [AW-1:0]                push_col,
  output item_flags_t                  push_flags,
  input  wire logic                    q_full
);

  localparam int CMP_W = (WD_W > CFG_WIDTH_W) ? WD_W : CFG_WIDTH_W;

  logic [CMP_W-1:0] width_ext;
  logic [WD_W-1:0]  wd;
  logic [ROW_W-1:0] ht;
  logic [AW-1:0]    col;
  logic [AW-1:0]    col_next;
  logic [ROW_W-1:0] row;
  logic [ROW_W-1:0] row_next;
  logic             accept;
  logic             is_drain;
  logic             drop;
  logic             start_new;
  logic [AW-1:0]    c_use;
  logic [ROW_W-1:0] r_use;
  logic [WD_W-1:0]  c_inc;
  logic             row_end;

  assign width_ext = CMP_W'(image_width);

  always_comb begin
    if (width_ext < CMP_W'(MIN_SIZE)) begin
      wd = WD_W'(MIN_SIZE);
    end else if (width_ext > CMP_W'(MAX_WIDTH)) begin
      wd = WD_W'(MAX_WIDTH);
    end else begin
      wd = WD_W'(width_ext);
    end
    if (image_height < CFG_HEIGHT_W'(MIN_SIZE)) begin
      ht = ROW_W'(MIN_SIZE);
    end else if (image_height > CFG_HEIGHT_W'(HEIGHT_LIMIT)) begin
      ht = ROW_W'(HEIGHT_LIMIT);
    end else begin
      ht = ROW_W'(image_height);
    end
  end

  assign item_stall = q_full;
  assign accept     = item_valid && !q_full;
  assign is_drain   = (cmd == CMD_DRAIN);
  // drain ticks only count once the frame's pixels are all in
  assign drop       = is_drain && (row < ht);
  // a pixel after the frame end starts the next frame
  assign start_new  = !is_drain && (row >= ht);
  assign c_use      = start_new ? '0 : col;
  assign r_use      = start_new ? '0 : row;
  assign c_inc      = WD_W'(c_use) + WD_W'(1);
  assign row_end    = (c_inc >= wd);

  assign push       = accept && !drop;
  assign push_pixel = is_drain ? '0 : pixel_in;
  assign push_col   = c_use;

  always_comb begin
    push_flags.emit     = (r_use >= ROW_W'(2)) ||
                          ((r_use == ROW_W'(1)) && (c_use >= AW'(1)));
    push_flags.interior = (c_use >= AW'(2)) && (r_use >= ROW_W'(2)) &&
                          (r_use <= ht - ROW_W'(1));
    push_flags.last     = (r_use == ht + ROW_W'(1)) && (c_use == '0);
  end

  always_comb begin
    col_next = col;
    row_next = row;
    if (restart) begin
      col_next = '0;
      row_next = '0;
    end else if (push) begin
      if (push_flags.last) begin
        col_next = '0;
        row_next = '0;
      end else if (row_end) begin
        col_next = '0;
        row_next = r_use + ROW_W'(1);
      end else begin
        col_next = c_inc[AW-1:0];
        row_next = r_use;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else begin
      col <= col_next;
      row <= row_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/cgc_back.sv
// back end: line buffer memory, 3x3 window, gap test and output register
// depends on cgc_pkg
`default_nettype none

module cgc_back import cgc_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT,
  localparam int AW       = $clog2(MAX_WIDTH)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_valid,
  input  wire logic [PIX_W-1:0]  q_pixel,
  input  wire logic [AW-1:0]     q_col,
  input  wire item_flags_t       q_flags,
  output logic                   q_pop,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output logic [PIX_W-1:0]       pixel_out,
  output logic                   last_of_frame,
  output back_status_t           status
);

  localparam int LINE_W = 2 * PIX_W;

  // upper row in the high byte, middle row in the low byte
  logic [LINE_W-1:0] line_mem [MAX_WIDTH];
  logic [LINE_W-1:0] ram_q;

  logic              s1_valid;
  logic [PIX_W-1:0]  s1_pixel;
  logic [AW-1:0]     s1_col;
  item_flags_t       s1_flags;
  logic              s1_fwd;
  logic [LINE_W-1:0] s1_fwd_line;

  // window columns 1 and 2 before the next shift
  logic [PIX_W-1:0]  win [3][2];

  logic [LINE_W-1:0] line_rd;
  logic [PIX_W-1:0]  top;
  logic [PIX_W-1:0]  mid;
  logic [LINE_W-1:0] wr_line;
  logic              adv;
  logic              fill;
  logic [PIX_W-1:0]  result;

  assign line_rd = s1_fwd ? s1_fwd_line : ram_q;
  assign top     = line_rd[LINE_W-1 -: PIX_W];
  assign mid     = line_rd[PIX_W-1:0];
  assign wr_line = {mid, s1_pixel};

  assign adv   = s1_valid && (!s1_flags.emit || !result_valid || !result_stall);
  assign q_pop = q_valid && (!s1_valid || adv);

  assign fill   = s1_flags.interior &&
                  gap_found(win[0][0], win[0][1], top,
                            win[1][0], mid,
                            win[2][0], win[2][1], s1_pixel);
  assign result = fill ? FILL_VALUE : win[1][1];

  assign status.busy    = s1_valid;
  assign status.advance = adv;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      ram_q <= line_mem[q_col];
    end
    if (adv) begin
      line_mem[s1_col] <= wr_line;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_pixel    <= q_pixel;
      s1_col      <= q_col;
      s1_flags    <= q_flags;
      // same column written on this edge: take the new line
      s1_fwd      <= adv && (s1_col == q_col);
      s1_fwd_line <= wr_line;
    end
    if (adv && s1_flags.emit) begin
      pixel_out     <= result;
      last_of_frame <= s1_flags.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        win[k][0] <= '0;
        win[k][1] <= '0;
      end
    end else begin
      if (q_pop) begin
        s1_valid <= 1'b1;
      end else if (adv) begin
        s1_valid <= 1'b0;
      end
      if (adv && s1_flags.emit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      if (adv) begin
        win[0][0] <= win[0][1];
        win[1][0] <= win[1][1];
        win[2][0] <= win[2][1];
        win[0][1] <= top;
        win[1][1] <= mid;
        win[2][1] <= s1_pixel;
      end
    end
  end

endmodule

`default_nettype wire
